[hw/rtl/wdc_pkg.sv]
// wdc_pkg: shared types and constants of the window distinct counter
// sequencer state codes and the histogram command group
// no dependencies
package wdc_pkg;

	localparam int FIELD_W = 10;
	localparam int COUNT_W = 11;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_PLAN,
		ST_FETCH,
		ST_ADJ
	} state_t;

	typedef struct packed {
		logic clear;
		logic zero_count;
		logic adjust;
		logic drop;
	} hist_cmd_t;

endpackage

[hw/rtl/wdc_elem_store.sv]
// wdc_elem_store: element code memory, one write port, one registered read port
// depends on nothing but its parameters
module wdc_elem_store #(
	parameter int ARRAY_DEPTH = 1024,
	parameter int VALUE_CODES = 1024
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [$clog2(ARRAY_DEPTH)-1:0] waddr,
	input  logic [$clog2(VALUE_CODES)-1:0] wdata,
	input  logic [$clog2(ARRAY_DEPTH)-1:0] raddr,
	output logic [$clog2(VALUE_CODES)-1:0] rdata
);

	localparam int VW = $clog2(VALUE_CODES);

	logic [VW-1:0] mem [ARRAY_DEPTH];
	logic [VW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/wdc_histogram.sv]
// wdc_histogram: per-code occurrence memory with the shared +/-1 adjust unit
// and the running distinct count; uses wdc_pkg
module wdc_histogram #(
	parameter int ARRAY_DEPTH = 1024,
	parameter int VALUE_CODES = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  wdc_pkg::hist_cmd_t               cmd,
	input  logic [$clog2(VALUE_CODES)-1:0]   clr_addr,
	input  logic [$clog2(VALUE_CODES)-1:0]   code,
	output logic [$clog2(ARRAY_DEPTH+1)-1:0] distinct
);

	localparam int VW = $clog2(VALUE_CODES);
	localparam int HW = $clog2(ARRAY_DEPTH + 1);

	logic [HW-1:0] mem [VALUE_CODES];
	logic [HW-1:0] rdata_q;
	logic [VW-1:0] addr_q;
	logic [HW-1:0] distinct_q;
	logic [HW-1:0] sum;
	logic [HW-1:0] distinct_d;
	logic          wen;
	logic          inc;
	logic          dec;

	// one adder serves both increment and decrement
	always_comb begin
		sum = rdata_q + (cmd.drop ? {HW{1'b1}} : HW'(1));
		wen = !cmd.drop || (rdata_q != '0);
		inc = !cmd.drop && (rdata_q == '0);
		dec = cmd.drop && (rdata_q == HW'(1)) && (distinct_q != '0);
		distinct_d = distinct_q;
		if (inc) begin
			distinct_d = distinct_q + HW'(1);
		end else if (dec) begin
			distinct_d = distinct_q - HW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			mem[clr_addr] <= '0;
		end else if (cmd.adjust && wen) begin
			mem[addr_q] <= sum;
		end
		rdata_q <= mem[code];
		addr_q  <= code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			distinct_q <= '0;
		end else if (cmd.zero_count) begin
			distinct_q <= '0;
		end else if (cmd.adjust) begin
			distinct_q <= distinct_d;
		end
	end

	assign distinct = distinct_q;

endmodule

[hw/rtl/wdc_seq.sv]
// wdc_seq: sequencer for loads, queries, clearing sweeps and window edge steps
// drives the element store and histogram; uses wdc_pkg
module wdc_seq #(
	parameter int ARRAY_DEPTH = 1024,
	parameter int VALUE_CODES = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             mode,
	input  logic [wdc_pkg::FIELD_W-1:0]      position,
	input  logic [wdc_pkg::FIELD_W-1:0]      value_code,
	input  logic [wdc_pkg::FIELD_W-1:0]      left_bound,
	input  logic [wdc_pkg::FIELD_W-1:0]      right_bound,
	output logic                             busy,
	output logic                             done,
	output logic [wdc_pkg::COUNT_W-1:0]      distinct_count,
	output logic                             bad_range,
	output logic                             store_we,
	output logic [$clog2(ARRAY_DEPTH)-1:0]   store_waddr,
	output logic [$clog2(VALUE_CODES)-1:0]   store_wdata,
	output logic [$clog2(ARRAY_DEPTH)-1:0]   store_raddr,
	output wdc_pkg::hist_cmd_t               hist_cmd,
	output logic [$clog2(VALUE_CODES)-1:0]   hist_clr_addr,
	input  logic [$clog2(ARRAY_DEPTH+1)-1:0] distinct
);

	localparam int AW   = $clog2(ARRAY_DEPTH);
	localparam int VW   = $clog2(VALUE_CODES);
	localparam int PW   = $clog2(ARRAY_DEPTH + 1);
	localparam int MAXD = (ARRAY_DEPTH > VALUE_CODES) ? ARRAY_DEPTH : VALUE_CODES;
	localparam int CW   = $clog2(MAXD);
	localparam logic [31:0] AD32 = 32'(ARRAY_DEPTH);
	localparam logic [31:0] VC32 = 32'(VALUE_CODES);

	wdc_pkg::state_t state_q, state_d;

	logic [CW-1:0] sweep_q;
	logic          stale_q;
	logic [PW-1:0] start_w_q;
	logic [PW-1:0] end_w_q;
	logic [PW-1:0] lo_q;
	logic [PW-1:0] end_q;
	logic          drop_q;
	logic          done_q;
	logic          bad_q;
	logic [wdc_pkg::COUNT_W-1:0] count_q;

	logic [31:0] pos32, code32, lo32, hi32, hisat32, end32, sweep32, dist32;
	logic        load_ok, query_bad, query_out, query_go, sweep_last, clear_last;

	logic          mv_valid;
	logic          mv_drop;
	logic [PW-1:0] mv_pos;
	logic [PW-1:0] mv_start_d;
	logic [PW-1:0] mv_end_d;

	always_comb begin
		pos32      = 32'(position);
		code32     = 32'(value_code);
		lo32       = 32'(left_bound);
		hi32       = 32'(right_bound);
		hisat32    = (hi32 >= AD32) ? (AD32 - 32'd1) : hi32;
		end32      = hisat32 + 32'd1;
		sweep32    = 32'(sweep_q);
		dist32     = 32'(distinct);
		load_ok    = (pos32 < AD32) && (code32 < VC32);
		query_bad  = lo32 > hi32;
		query_out  = !query_bad && (lo32 >= AD32);
		query_go   = !query_bad && !query_out;
		sweep_last = sweep_q == CW'(MAXD - 1);
		clear_last = sweep_q == CW'(VALUE_CODES - 1);
	end

	// widen first, then narrow
	always_comb begin
		mv_valid   = 1'b1;
		mv_drop    = 1'b0;
		mv_pos     = end_w_q;
		mv_start_d = start_w_q;
		mv_end_d   = end_w_q;
		if (end_w_q < end_q) begin
			mv_pos   = end_w_q;
			mv_end_d = end_w_q + PW'(1);
		end else if (start_w_q > lo_q) begin
			mv_pos     = start_w_q - PW'(1);
			mv_start_d = start_w_q - PW'(1);
		end else if (end_w_q > end_q) begin
			mv_drop  = 1'b1;
			mv_pos   = end_w_q - PW'(1);
			mv_end_d = end_w_q - PW'(1);
		end else if (start_w_q < lo_q) begin
			mv_drop    = 1'b1;
			mv_pos     = start_w_q;
			mv_start_d = start_w_q + PW'(1);
		end else begin
			mv_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wdc_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		store_we      = 1'b0;
		store_waddr   = pos32[AW-1:0];
		store_wdata   = code32[VW-1:0];
		store_raddr   = mv_pos[AW-1:0];
		hist_cmd      = '0;
		hist_clr_addr = sweep_q[VW-1:0];
		unique case (state_q)
			wdc_pkg::ST_INIT: begin
				store_we       = sweep32 < AD32;
				store_waddr    = sweep_q[AW-1:0];
				store_wdata    = '0;
				hist_cmd.clear = sweep32 < VC32;
				if (sweep_last) begin
					state_d = wdc_pkg::ST_IDLE;
				end
			end
			wdc_pkg::ST_IDLE: begin
				if (start && !mode) begin
					store_we = load_ok;
				end else if (start && mode && query_go) begin
					state_d = stale_q ? wdc_pkg::ST_CLEAR : wdc_pkg::ST_PLAN;
				end
			end
			wdc_pkg::ST_CLEAR: begin
				hist_cmd.clear      = 1'b1;
				hist_cmd.zero_count = 1'b1;
				if (clear_last) begin
					state_d = wdc_pkg::ST_PLAN;
				end
			end
			wdc_pkg::ST_PLAN: begin
				state_d = mv_valid ? wdc_pkg::ST_FETCH : wdc_pkg::ST_IDLE;
			end
			wdc_pkg::ST_FETCH: begin
				state_d = wdc_pkg::ST_ADJ;
			end
			wdc_pkg::ST_ADJ: begin
				hist_cmd.adjust = 1'b1;
				hist_cmd.drop   = drop_q;
				state_d         = wdc_pkg::ST_PLAN;
			end
			default: begin
				state_d = wdc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q   <= '0;
			stale_q   <= 1'b1;
			start_w_q <= '0;
			end_w_q   <= '0;
			done_q    <= 1'b0;
			bad_q     <= 1'b0;
			count_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				wdc_pkg::ST_INIT: begin
					sweep_q <= sweep_last ? '0 : sweep_q + CW'(1);
				end
				wdc_pkg::ST_IDLE: begin
					sweep_q <= '0;
					if (start && !mode && load_ok) begin
						stale_q <= 1'b1;
					end else if (start && mode && !query_go) begin
						done_q  <= 1'b1;
						bad_q   <= query_bad;
						count_q <= '0;
					end
				end
				wdc_pkg::ST_CLEAR: begin
					sweep_q <= clear_last ? '0 : sweep_q + CW'(1);
					if (clear_last) begin
						start_w_q <= '0;
						end_w_q   <= '0;
						stale_q   <= 1'b0;
					end
				end
				wdc_pkg::ST_PLAN: begin
					if (mv_valid) begin
						start_w_q <= mv_start_d;
						end_w_q   <= mv_end_d;
					end else begin
						done_q  <= 1'b1;
						bad_q   <= 1'b0;
						count_q <= dist32[wdc_pkg::COUNT_W-1:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == wdc_pkg::ST_IDLE && start) begin
			lo_q  <= lo32[PW-1:0];
			end_q <= end32[PW-1:0];
		end
		if (state_q == wdc_pkg::ST_PLAN) begin
			drop_q <= mv_drop;
		end
	end

	assign busy           = state_q != wdc_pkg::ST_IDLE;
	assign done           = done_q;
	assign bad_range      = bad_q;
	assign distinct_count = count_q;

endmodule

[hw/rtl/window_distinct_counter.sv]
// window_distinct_counter: top level of the sliding-window distinct value counter
// instantiates wdc_seq, wdc_elem_store and wdc_histogram; uses wdc_pkg
//
// command channel: a beat is taken at a rising edge with start high and busy low.
// mode 0 writes value_code at position (out-of-range loads are dropped) and marks
// the window stale; it gives no result and leaves busy low.
// mode 1 queries [left_bound, right_bound]; the result beat is distinct_count and
// bad_range, shown for exactly one cycle with done high. the receiver cannot stall.
// reversed bounds or a range past the store give a result in the cycle after accept.
// otherwise: a stale window first has every histogram entry cleared, then every
// one-position edge move passes through PLAN (element read), FETCH (histogram
// read) and ADJ (histogram write-back through the shared +/-1 unit), and the
// result is registered in the PLAN state that finds no move left.
// after reset the block is busy while it clears the element store and the
// histogram, one entry per cycle.
module window_distinct_counter #(
	parameter int ARRAY_DEPTH = 1024,
	parameter int VALUE_CODES = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        mode,
	input  logic [wdc_pkg::FIELD_W-1:0] position,
	input  logic [wdc_pkg::FIELD_W-1:0] value_code,
	input  logic [wdc_pkg::FIELD_W-1:0] left_bound,
	input  logic [wdc_pkg::FIELD_W-1:0] right_bound,
	output logic                        done,
	output logic [wdc_pkg::COUNT_W-1:0] distinct_count,
	output logic                        bad_range
);

	localparam int AW = $clog2(ARRAY_DEPTH);
	localparam int VW = $clog2(VALUE_CODES);
	localparam int HW = $clog2(ARRAY_DEPTH + 1);

	logic               store_we;
	logic [AW-1:0]      store_waddr;
	logic [VW-1:0]      store_wdata;
	logic [AW-1:0]      store_raddr;
	logic [VW-1:0]      store_rdata;
	wdc_pkg::hist_cmd_t hist_cmd;
	logic [VW-1:0]      hist_clr_addr;
	logic [HW-1:0]      distinct;

	wdc_seq #(
		.ARRAY_DEPTH(ARRAY_DEPTH),
		.VALUE_CODES(VALUE_CODES)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.mode          (mode),
		.position      (position),
		.value_code    (value_code),
		.left_bound    (left_bound),
		.right_bound   (right_bound),
		.busy          (busy),
		.done          (done),
		.distinct_count(distinct_count),
		.bad_range     (bad_range),
		.store_we      (store_we),
		.store_waddr   (store_waddr),
		.store_wdata   (store_wdata),
		.store_raddr   (store_raddr),
		.hist_cmd      (hist_cmd),
		.hist_clr_addr (hist_clr_addr),
		.distinct      (distinct)
	);

	wdc_elem_store #(
		.ARRAY_DEPTH(ARRAY_DEPTH),
		.VALUE_CODES(VALUE_CODES)
	) u_store (
		.clk  (clk),
		.we   (store_we),
		.waddr(store_waddr),
		.wdata(store_wdata),
		.raddr(store_raddr),
		.rdata(store_rdata)
	);

	wdc_histogram #(
		.ARRAY_DEPTH(ARRAY_DEPTH),
		.VALUE_CODES(VALUE_CODES)
	) u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (hist_cmd),
		.clr_addr(hist_clr_addr),
		.code    (store_rdata),
		.distinct(distinct)
	);

	a_reversed_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && mode && (left_bound > right_bound)
		|=> done && bad_range && (distinct_count == '0))
		else $error("reversed bounds did not give an error beat");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !mode |=> !done)
		else $error("load beat produced a result");

	a_bad_means_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && bad_range |-> distinct_count == '0)
		else $error("error beat with nonzero count");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> 32'(distinct_count) <= 32'(ARRAY_DEPTH))
		else $error("distinct count above array depth");

endmodule

[tb/window_distinct_counter_tb.sv]
// window_distinct_counter_tb: self-checking bench for the sliding-window distinct counter
// directed table of load/query beats, then bursts of loads and drifting queries,
// every result compared with a typed value or an in-bench window model; depends on wdc_pkg and the dut
module window_distinct_counter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FIELD_W = wdc_pkg::FIELD_W;
	localparam int COUNT_W = wdc_pkg::COUNT_W;
	localparam int DEPTH = 1024;
	localparam int CODES = 1024;
	localparam int HOT_SPAN = 64;
	localparam int STALL_LIMIT = 40000;
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef struct packed {
		logic               mode;
		logic [FIELD_W-1:0] pos;
		logic [FIELD_W-1:0] code;
		logic [FIELD_W-1:0] lo;
		logic [FIELD_W-1:0] hi;
	} beat_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               bad;
	} tally_t;

	typedef struct packed {
		beat_t  cmd;
		logic   known;
		tally_t typed;
	} row_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               mode;
	logic [FIELD_W-1:0] position;
	logic [FIELD_W-1:0] value_code;
	logic [FIELD_W-1:0] left_bound;
	logic [FIELD_W-1:0] right_bound;
	logic               done;
	logic [COUNT_W-1:0] distinct_count;
	logic               bad_range;

	logic [FIELD_W-1:0] store_mirror [DEPTH];
	int                 hist_mirror [CODES];
	int                 win_lo;
	int                 win_end;
	int                 live_distinct;
	bit                 mirror_stale;

	tally_t tally_q [$];
	int     errors;
	int     results_seen;
	int     loads_sent;
	int     queries_sent;
	int     reversed_sent;
	int     idle_cycles = 0;

	row_t directed [22] = '{
		'{'{MODE_QUERY, 10'd0, 10'd0, 10'd0, 10'd1023}, 1'b1, '{11'd1, 1'b0}},
		'{'{MODE_QUERY, 10'd0, 10'd0, 10'd1023, 10'd0}, 1'b1, '{11'd0, 1'b1}},
		'{'{MODE_QUERY, 10'd0, 10'd0, 10'd1, 10'd0}, 1'b1, '{11'd0, 1'b1}},
		'{'{MODE_LOAD, 10'd1023, 10'd1023, 10'd0, 10'd0}, 1'b0, '0},
		'{'{MODE_LOAD, 10'd0, 10'h155, 10'd0, 10'd0}, 1'b0, '0},
		'{'{MODE_LOAD, 10'd1, 10'h2aa, 10'd0, 10'd0}, 1'b0, '0},
		'{'{MODE_QUERY, 10'd0, 10'd0, 10'd0, 10'd0}, 1'b1, '{11'd1, 1'b0}},
		'{'{MODE_QUERY, 10'd0, 10'd0, 10'd1023, 10'd1023}, 1'b1, '{11'd1, 1'b0}},
		'{'{MODE_QUERY, 10'd0, 10'd0, 10'd0, 10'd1023}, 1'b1, '{11'd4, 1'b0}},
		'{'{MODE_QUERY, 10'd0, 10'd0, 10'd0, 10'd1}, 1'b0, '0},
		'{'{MODE_QUERY, 10'd0, 10'd0, 10'd512, 10'd1022}, 1'b1, '{11'd1, 1'b0}},
		'{'{MODE_LOAD, 10'd2, 10'h155, 10'd0, 10'd0}, 1'b0, '0},
		'{'{MODE_QUERY, 10'd0, 10'd0, 10'd0, 10'd2}, 1'b1, '{11'd2, 1'b0}},
		'{'{MODE_QUERY, 10'd0, 10'd0, 10'd1, 10'd2}, 1'b0, '0},
		'{'{MODE_QUERY, 10'd0, 10'd0, 10'd2, 10'd2}, 1'b0, '0},
		'{'{MODE_LOAD, 10'd1023, 10'd0, 10'd0, 10'd0}, 1'b0, '0},
		'{'{MODE_QUERY, 10'd0, 10'd0, 10'd1000, 10'd1023}, 1'b1, '{11'd1, 1'b0}},
		'{'{MODE_QUERY, 10'd0, 10'd0, 10'd0, 10'h3ff}, 1'b0, '0},
		'{'{MODE_QUERY, 10'd0, 10'd0, 10'd5, 10'd5}, 1'b0, '0},
		'{'{MODE_QUERY, 10'd0, 10'd0, 10'h3ff, 10'h3fe}, 1'b1, '{11'd0, 1'b1}},
		'{'{MODE_LOAD, 10'h2aa, 10'h155, 10'd0, 10'd0}, 1'b0, '0},
		'{'{MODE_QUERY, 10'd0, 10'd0, 10'h155, 10'h2aa}, 1'b0, '0}
	};

	window_distinct_counter #(
		.ARRAY_DEPTH(DEPTH),
		.VALUE_CODES(CODES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.position(position),
		.value_code(value_code),
		.left_bound(left_bound),
		.right_bound(right_bound),
		.done(done),
		.distinct_count(distinct_count),
		.bad_range(bad_range)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic void hist_add(int p);
		int v;
		v = int'(store_mirror[p % DEPTH]) % CODES;
		if (hist_mirror[v] == 0) begin
			live_distinct++;
		end
		hist_mirror[v]++;
	endfunction

	function automatic void hist_drop(int p);
		int v;
		v = int'(store_mirror[p % DEPTH]) % CODES;
		if (hist_mirror[v] != 0) begin
			hist_mirror[v]--;
			if (hist_mirror[v] == 0 && live_distinct > 0) begin
				live_distinct--;
			end
		end
	endfunction

	function automatic void store_load(int p, int c);
		if (p < DEPTH && c < CODES) begin
			store_mirror[p] = FIELD_W'(c);
			mirror_stale = 1'b1;
		end
	endfunction

	// widen both edges before narrowing, as the block does
	function automatic tally_t window_count(int lo, int hi);
		tally_t r;
		int     stop;
		r = '0;
		if (lo > hi) begin
			r.bad = 1'b1;
			return r;
		end
		if (lo >= DEPTH) begin
			return r;
		end
		if (hi >= DEPTH) begin
			hi = DEPTH - 1;
		end
		stop = hi + 1;
		if (mirror_stale) begin
			foreach (hist_mirror[i]) begin
				hist_mirror[i] = 0;
			end
			win_lo = 0;
			win_end = 0;
			live_distinct = 0;
			mirror_stale = 1'b0;
		end
		while (win_end < stop) begin
			hist_add(win_end);
			win_end++;
		end
		while (win_lo > lo) begin
			win_lo--;
			hist_add(win_lo);
		end
		while (win_end > stop) begin
			win_end--;
			hist_drop(win_end);
		end
		while (win_lo < lo) begin
			hist_drop(win_lo);
			win_lo++;
		end
		r.count = COUNT_W'(live_distinct);
		return r;
	endfunction

	task automatic flag_mismatch(string what);
		if (errors < 40) begin
			$display("mismatch at %0t: %s", $realtime, what);
		end
		errors++;
	endtask

	task automatic issue_beat(beat_t b, logic known, tally_t typed, int idle_pct);
		tally_t guess;
		if ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start = 1'b0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end else begin
			@(negedge clk);
		end
		start = 1'b1;
		mode = b.mode;
		position = b.pos;
		value_code = b.code;
		left_bound = b.lo;
		right_bound = b.hi;
		do @(posedge clk); while (busy);
		if (b.mode == MODE_LOAD) begin
			store_load(int'(b.pos), int'(b.code));
			loads_sent++;
		end else begin
			guess = window_count(int'(b.lo), int'(b.hi));
			tally_q.insert(tally_q.size(), known ? typed : guess);
			queries_sent++;
			if (b.lo > b.hi) begin
				reversed_sent++;
			end
		end
	endtask

	// bursts of loads in a small hot region, then queries whose edges drift a little, with occasional random beats
	task automatic random_traffic(int items, int idle_pct);
		beat_t b;
		int    sent;
		int    lo;
		int    hi;
		int    n;
		int    t;
		sent = 0;
		lo = 0;
		hi = HOT_SPAN / 2;
		while (sent < items) begin
			if ($urandom_range(99) < 10) begin
				b.mode = 1'($urandom_range(1));
				b.pos = FIELD_W'($urandom());
				b.code = FIELD_W'($urandom());
				b.lo = FIELD_W'($urandom());
				b.hi = FIELD_W'($urandom());
				issue_beat(b, 1'b0, '0, idle_pct);
				sent++;
			end else begin
				n = $urandom_range(3);
				repeat (n) begin
					b = '0;
					b.mode = MODE_LOAD;
					b.pos = FIELD_W'($urandom_range(HOT_SPAN - 1));
					b.code = FIELD_W'($urandom_range(15));
					issue_beat(b, 1'b0, '0, idle_pct);
					sent++;
				end
				n = $urandom_range(6, 1);
				repeat (n) begin
					lo = lo + int'($urandom_range(8)) - 4;
					hi = hi + int'($urandom_range(8)) - 4;
					lo = (lo < 0) ? 0 : (lo > HOT_SPAN - 1) ? HOT_SPAN - 1 : lo;
					hi = (hi < 0) ? 0 : (hi > HOT_SPAN - 1) ? HOT_SPAN - 1 : hi;
					if (lo > hi) begin
						t = lo;
						lo = hi;
						hi = t;
					end
					b = '0;
					b.mode = MODE_QUERY;
					b.pos = FIELD_W'($urandom());
					b.code = FIELD_W'($urandom());
					if (lo != hi && $urandom_range(99) < 5) begin
						b.lo = FIELD_W'(hi);
						b.hi = FIELD_W'(lo);
					end else begin
						b.lo = FIELD_W'(lo);
						b.hi = FIELD_W'(hi);
					end
					issue_beat(b, 1'b0, '0, idle_pct);
					sent++;
				end
			end
		end
	endtask

	always @(posedge clk) begin
		tally_t want;
		if (arst_n && done) begin
			if (tally_q.size() == 0) begin
				flag_mismatch($sformatf("unexpected result beat: count %0d bad_range %0b",
					distinct_count, bad_range));
			end else begin
				want = tally_q.pop_front();
				if (distinct_count !== want.count) begin
					flag_mismatch($sformatf("distinct_count %0d, want %0d",
						distinct_count, want.count));
				end
				if (bad_range !== want.bad) begin
					flag_mismatch($sformatf("bad_range %0b, want %0b", bad_range, want.bad));
				end
				results_seen++;
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("no beat for %0d cycles, giving up", STALL_LIMIT);
			$display("FAIL window_distinct_counter");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		mode = MODE_LOAD;
		position = '0;
		value_code = '0;
		left_bound = '0;
		right_bound = '0;
		errors = 0;
		results_seen = 0;
		loads_sent = 0;
		queries_sent = 0;
		reversed_sent = 0;
		foreach (store_mirror[i]) begin
			store_mirror[i] = '0;
		end
		foreach (hist_mirror[i]) begin
			hist_mirror[i] = 0;
		end
		win_lo = 0;
		win_end = 0;
		live_distinct = 0;
		mirror_stale = 1'b1;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i]) begin
			issue_beat(directed[i].cmd, directed[i].known, directed[i].typed, 0);
		end
		random_traffic(140, 0);
		random_traffic(130, 67);
		random_traffic(130, 14);

		@(negedge clk);
		start = 1'b0;
		while (tally_q.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);

		$display("sent %0d loads and %0d queries (%0d with reversed bounds)",
			loads_sent, queries_sent, reversed_sent);
		$display("checked %0d result beats, %0d mismatches", results_seen, errors);
		if (errors == 0) begin
			$display("PASS window_distinct_counter");
		end else begin
			$display("FAIL window_distinct_counter");
		end
		$finish;
	end

endmodule
